// ----- sv/dls_pkg.sv -----
// dls_pkg: shared types, codes and reset values for the door lock sequencer
// used by dls_core and door_lock_sequencer; depends on nothing else
package dls_pkg;

  // widths fixed by the register map and the word fields
  localparam int CFG_W       = 16;
  localparam int PRESS_W     = 10;
  localparam int TIMER_W_DEF = 16;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // register reset values
  localparam logic [CFG_W-1:0]   CLOSE_WAIT_TIMEOUT_RST  = 16'd10000;
  localparam logic [CFG_W-1:0]   CLOSE_TO_LOCK_DELAY_RST = 16'd1000;
  localparam logic [CFG_W-1:0]   OPENING_TRAVEL_RST      = 16'd7000;
  localparam logic [CFG_W-1:0]   CLOSING_TRAVEL_RST      = 16'd7000;
  localparam logic [PRESS_W-1:0] BUTTON_PRESS_RST        = 10'd120;

  // register indexes (word address bits)
  localparam logic [2:0] REG_CLOSE_WAIT_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_CLOSE_TO_LOCK_DELAY = 3'd1;
  localparam logic [2:0] REG_OPENING_TRAVEL_TIME = 3'd2;
  localparam logic [2:0] REG_CLOSING_TRAVEL_TIME = 3'd3;
  localparam logic [2:0] REG_BUTTON_PRESS_TIME   = 3'd4;

  // input function codes
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_ACTION = 1'b1;

  // action codes
  localparam logic [1:0] ACT_CLOSE_NOW   = 2'd0;
  localparam logic [1:0] ACT_LOCK_CLOSED = 2'd1;
  localparam logic [1:0] ACT_UNLOCK      = 2'd2;
  localparam logic [1:0] ACT_TOGGLE      = 2'd3;

  // door sensor codes
  localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
  localparam logic [1:0] DOOR_CLOSED  = 2'd1;
  localparam logic [1:0] DOOR_OPEN    = 2'd2;
  localparam logic [1:0] DOOR_INVALID = 2'd3;

  // lock status codes
  localparam logic [1:0] LOCK_UNKNOWN  = 2'd0;
  localparam logic [1:0] LOCK_LOCKED   = 2'd1;
  localparam logic [1:0] LOCK_UNLOCKED = 2'd2;

  // sequence status codes as reported
  localparam logic [1:0] SEQ_CODE_IDLE   = 2'd0;
  localparam logic [1:0] SEQ_CODE_MOVING = 2'd1;
  localparam logic [1:0] SEQ_CODE_WAIT   = 2'd2;
  localparam logic [1:0] SEQ_CODE_DELAY  = 2'd3;

  // led modes
  localparam logic [1:0] LED_OFF        = 2'd0;
  localparam logic [1:0] LED_RED        = 2'd1;
  localparam logic [1:0] LED_YELLOW_RED = 2'd2;
  localparam logic [1:0] LED_GREEN      = 2'd3;

  // sequencer state
  typedef enum logic [3:0] {
    SEQ_IDLE   = 4'b0001,
    SEQ_MOVING = 4'b0010,
    SEQ_WAIT   = 4'b0100,
    SEQ_DELAY  = 4'b1000
  } seq_state_t;

  // lock drive state
  typedef enum logic [2:0] {
    DRV_STILL   = 3'b001,
    DRV_OPENING = 3'b010,
    DRV_CLOSING = 3'b100
  } drive_state_t;

  typedef struct packed {
    logic       func;
    logic [1:0] action;
    logic [1:0] door_sense;
  } in_word_t;

  typedef struct packed {
    logic [1:0] lock_status;
    logic [1:0] sequence_status;
    logic [1:0] led_mode;
    logic       open_button;
    logic       close_button;
    logic       drive_moving;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0]   close_wait_timeout;
    logic [CFG_W-1:0]   close_to_lock_delay;
    logic [CFG_W-1:0]   opening_travel_time;
    logic [CFG_W-1:0]   closing_travel_time;
    logic [PRESS_W-1:0] button_press_time;
  } cfg_t;

endpackage

// ----- sv/dls_core.sv -----
// dls_core: sequencer state, timers and the single-pass update for one word
// depends on dls_pkg
module dls_core #(
  parameter int TIMER_WIDTH = dls_pkg::TIMER_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  dls_pkg::in_word_t  in_word,
  input  dls_pkg::cfg_t      cfg,
  output dls_pkg::out_word_t result
);

  localparam int CmpW = (TIMER_WIDTH > dls_pkg::CFG_W) ? TIMER_WIDTH : dls_pkg::CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  // state registers
  logic [1:0]                  door_status, door_status_next;
  logic [1:0]                  lock_status, lock_status_next;
  dls_pkg::seq_state_t         seq_state, seq_state_next;
  dls_pkg::drive_state_t       drive_state, drive_state_next;
  logic [TIMER_WIDTH-1:0]      travel_timer, travel_timer_next;
  logic [TIMER_WIDTH-1:0]      wait_timer, wait_timer_next;
  logic [TIMER_WIDTH-1:0]      delay_timer, delay_timer_next;
  logic [dls_pkg::PRESS_W-1:0] press_counter, press_counter_next;
  logic                        press_is_open, press_is_open_next;
  logic [1:0]                  led, led_next;

  logic [1:0] act;
  logic       start_close;
  logic       start_open;

  // next state for one word
  always_comb begin
    door_status_next   = door_status;
    lock_status_next   = lock_status;
    seq_state_next     = seq_state;
    drive_state_next   = drive_state;
    travel_timer_next  = travel_timer;
    wait_timer_next    = wait_timer;
    delay_timer_next   = delay_timer;
    press_counter_next = press_counter;
    press_is_open_next = press_is_open;
    led_next           = led;
    act                = in_word.action;
    start_close        = 1'b0;
    start_open         = 1'b0;

    if (in_word.func == dls_pkg::FUNC_TICK) begin
      // sample door, advance saturating timers and button pulse
      door_status_next = (in_word.door_sense == dls_pkg::DOOR_INVALID) ?
                         dls_pkg::DOOR_UNKNOWN : in_word.door_sense;
      travel_timer_next = (travel_timer == TimerMax) ? travel_timer :
                          travel_timer + TIMER_WIDTH'(1);
      wait_timer_next   = (wait_timer == TimerMax) ? wait_timer :
                          wait_timer + TIMER_WIDTH'(1);
      delay_timer_next  = (delay_timer == TimerMax) ? delay_timer :
                          delay_timer + TIMER_WIDTH'(1);
      if (press_counter != '0) begin
        press_counter_next = press_counter - dls_pkg::PRESS_W'(1);
      end

      // end of drive travel
      if (drive_state == dls_pkg::DRV_OPENING &&
          CmpW'(travel_timer_next) > CmpW'(cfg.opening_travel_time)) begin
        drive_state_next = dls_pkg::DRV_STILL;
      end else if (drive_state == dls_pkg::DRV_CLOSING &&
                   CmpW'(travel_timer_next) > CmpW'(cfg.closing_travel_time)) begin
        drive_state_next = dls_pkg::DRV_STILL;
      end

      // move done
      if (seq_state_next == dls_pkg::SEQ_MOVING &&
          drive_state_next == dls_pkg::DRV_STILL) begin
        seq_state_next = dls_pkg::SEQ_IDLE;
        led_next       = dls_pkg::LED_OFF;
      end

      // waiting for the door to close
      if (seq_state_next == dls_pkg::SEQ_WAIT) begin
        if (CmpW'(wait_timer_next) > CmpW'(cfg.close_wait_timeout)) begin
          seq_state_next = dls_pkg::SEQ_IDLE;
          led_next       = dls_pkg::LED_OFF;
        end else if (door_status_next == dls_pkg::DOOR_CLOSED) begin
          seq_state_next   = dls_pkg::SEQ_DELAY;
          delay_timer_next = '0;
        end
      end

      // door must stay closed before locking
      if (seq_state_next == dls_pkg::SEQ_DELAY) begin
        if (door_status_next != dls_pkg::DOOR_CLOSED) begin
          seq_state_next = dls_pkg::SEQ_WAIT;
        end else if (CmpW'(delay_timer_next) > CmpW'(cfg.close_to_lock_delay)) begin
          start_close = 1'b1;
        end
      end
    end else begin
      // resolve toggle from the lock state
      if (act == dls_pkg::ACT_TOGGLE) begin
        act = (lock_status == dls_pkg::LOCK_UNKNOWN || lock_status == dls_pkg::LOCK_LOCKED) ?
              dls_pkg::ACT_UNLOCK : dls_pkg::ACT_LOCK_CLOSED;
      end
      // actions are ignored while moving
      if (seq_state != dls_pkg::SEQ_MOVING) begin
        if (act == dls_pkg::ACT_CLOSE_NOW) begin
          start_close = 1'b1;
        end else if (act == dls_pkg::ACT_LOCK_CLOSED) begin
          wait_timer_next = '0;
          seq_state_next  = dls_pkg::SEQ_WAIT;
          led_next        = dls_pkg::LED_YELLOW_RED;
        end else begin
          start_open = 1'b1;
        end
      end
    end

    // start a drive move
    if (start_close || start_open) begin
      travel_timer_next  = '0;
      press_counter_next = cfg.button_press_time;
      press_is_open_next = start_open;
      drive_state_next   = start_open ? dls_pkg::DRV_OPENING : dls_pkg::DRV_CLOSING;
      seq_state_next     = dls_pkg::SEQ_MOVING;
      lock_status_next   = start_open ? dls_pkg::LOCK_UNLOCKED : dls_pkg::LOCK_LOCKED;
      led_next           = start_open ? dls_pkg::LED_GREEN : dls_pkg::LED_RED;
    end
  end

  // result word from the updated state
  always_comb begin
    result.lock_status  = lock_status_next;
    result.led_mode     = led_next;
    result.open_button  = (press_counter_next != '0) && press_is_open_next;
    result.close_button = (press_counter_next != '0) && !press_is_open_next;
    result.drive_moving = (drive_state_next != dls_pkg::DRV_STILL);
    unique case (seq_state_next)
      dls_pkg::SEQ_IDLE:   result.sequence_status = dls_pkg::SEQ_CODE_IDLE;
      dls_pkg::SEQ_MOVING: result.sequence_status = dls_pkg::SEQ_CODE_MOVING;
      dls_pkg::SEQ_WAIT:   result.sequence_status = dls_pkg::SEQ_CODE_WAIT;
      dls_pkg::SEQ_DELAY:  result.sequence_status = dls_pkg::SEQ_CODE_DELAY;
      default:             result.sequence_status = dls_pkg::SEQ_CODE_IDLE;
    endcase
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      door_status   <= dls_pkg::DOOR_UNKNOWN;
      lock_status   <= dls_pkg::LOCK_UNKNOWN;
      seq_state     <= dls_pkg::SEQ_IDLE;
      drive_state   <= dls_pkg::DRV_STILL;
      travel_timer  <= '0;
      wait_timer    <= '0;
      delay_timer   <= '0;
      press_counter <= '0;
      press_is_open <= 1'b0;
      led           <= dls_pkg::LED_OFF;
    end else if (accept) begin
      door_status   <= door_status_next;
      lock_status   <= lock_status_next;
      seq_state     <= seq_state_next;
      drive_state   <= drive_state_next;
      travel_timer  <= travel_timer_next;
      wait_timer    <= wait_timer_next;
      delay_timer   <= delay_timer_next;
      press_counter <= press_counter_next;
      press_is_open <= press_is_open_next;
      led           <= led_next;
    end
  end

endmodule

// ----- sv/door_lock_sequencer.sv -----
// door_lock_sequencer: top level with register port and output skid stage
// depends on dls_pkg and dls_core
//
// Usage: each input word is either a 1 ms tick carrying the door sensor or an
// action (close now, lock once closed, unlock, toggle). Every input word gives
// exactly one output word: lock status, sequence status, led mode, button
// drive levels and drive motion after that word has been applied.
// Channels: in_valid/in_stall/in_word and out_valid/out_stall/out_word; a word
// moves at an edge with valid high and stall low.
// A taken word's result is registered in the output register, or in the skid
// register if out_stall holds it. One word per cycle while in_stall is low, set
// by the single-pass state update between state registers and output register.
// A stalled receiver fills the output register and then a one-word skid
// register; in_stall rises only when the skid register is full.
// The user writes registers over the APB-style port only while the block is
// idle; the block itself does not enforce this. pready is always high.
// Reset (synchronous, rst high) clears the sequencer to idle with unknown lock
// and door state, empties both output stages and loads register defaults.
module door_lock_sequencer #(
  parameter int TIMER_WIDTH = dls_pkg::TIMER_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dls_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dls_pkg::out_word_t           out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dls_pkg::PADDR_W-1:0]  paddr,
  input  logic [dls_pkg::PDATA_W-1:0]  pwdata,
  output logic [dls_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  dls_pkg::cfg_t      cfg;
  dls_pkg::out_word_t result;
  dls_pkg::out_word_t skid_word;
  logic               skid_valid;
  logic               accept;
  logic               cfg_write;
  logic [2:0]         reg_index;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_wait_timeout  <= dls_pkg::CLOSE_WAIT_TIMEOUT_RST;
      cfg.close_to_lock_delay <= dls_pkg::CLOSE_TO_LOCK_DELAY_RST;
      cfg.opening_travel_time <= dls_pkg::OPENING_TRAVEL_RST;
      cfg.closing_travel_time <= dls_pkg::CLOSING_TRAVEL_RST;
      cfg.button_press_time   <= dls_pkg::BUTTON_PRESS_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        dls_pkg::REG_CLOSE_WAIT_TIMEOUT:
          cfg.close_wait_timeout <= pwdata[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_CLOSE_TO_LOCK_DELAY:
          cfg.close_to_lock_delay <= pwdata[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_OPENING_TRAVEL_TIME:
          cfg.opening_travel_time <= pwdata[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_CLOSING_TRAVEL_TIME:
          cfg.closing_travel_time <= pwdata[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_BUTTON_PRESS_TIME:
          cfg.button_press_time <= pwdata[dls_pkg::PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      dls_pkg::REG_CLOSE_WAIT_TIMEOUT:  prdata = dls_pkg::PDATA_W'(cfg.close_wait_timeout);
      dls_pkg::REG_CLOSE_TO_LOCK_DELAY: prdata = dls_pkg::PDATA_W'(cfg.close_to_lock_delay);
      dls_pkg::REG_OPENING_TRAVEL_TIME: prdata = dls_pkg::PDATA_W'(cfg.opening_travel_time);
      dls_pkg::REG_CLOSING_TRAVEL_TIME: prdata = dls_pkg::PDATA_W'(cfg.closing_travel_time);
      dls_pkg::REG_BUTTON_PRESS_TIME:   prdata = dls_pkg::PDATA_W'(cfg.button_press_time);
      default:                          prdata = '0;
    endcase
  end

  // input handshake: stall only when the skid stage holds a word
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  dls_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_word),
    .cfg     (cfg),
    .result  (result)
  );

  // output register and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // output and skid words
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= result;
      end
    end else if (accept) begin
      skid_word <= result;
    end
  end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for door_lock_sequencer, status predicted per input word
// depends on dls_pkg and the door_lock_sequencer rtl; drives words, apb writes and stalls
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW        = dls_pkg::TIMER_W_DEF;
  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_LEN  = 300;

  // status predictor and in-order checker
  class lock_scoreboard;
    dls_pkg::cfg_t              cfg;
    logic [1:0]                 door_st;
    logic [1:0]                 lock_st;
    logic [1:0]                 seq_st;
    logic [1:0]                 led_st;
    dls_pkg::drive_state_t      drive_st;
    logic [TW-1:0]              travel_cnt;
    logic [TW-1:0]              wait_cnt;
    logic [TW-1:0]              delay_cnt;
    logic [dls_pkg::PRESS_W-1:0] press_left;
    logic                       press_open;
    dls_pkg::out_word_t         expected_status[$];
    int                         mismatches;
    int                         words_in;
    int                         words_checked;

    function new();
      cfg.close_wait_timeout  = dls_pkg::CLOSE_WAIT_TIMEOUT_RST;
      cfg.close_to_lock_delay = dls_pkg::CLOSE_TO_LOCK_DELAY_RST;
      cfg.opening_travel_time = dls_pkg::OPENING_TRAVEL_RST;
      cfg.closing_travel_time = dls_pkg::CLOSING_TRAVEL_RST;
      cfg.button_press_time   = dls_pkg::BUTTON_PRESS_RST;
      door_st    = dls_pkg::DOOR_UNKNOWN;
      lock_st    = dls_pkg::LOCK_UNKNOWN;
      seq_st     = dls_pkg::SEQ_CODE_IDLE;
      led_st     = dls_pkg::LED_OFF;
      drive_st   = dls_pkg::DRV_STILL;
      travel_cnt = '0;
      wait_cnt   = '0;
      delay_cnt  = '0;
      press_left = '0;
      press_open = 1'b0;
      mismatches = 0;
      words_in   = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      unique case (idx)
        dls_pkg::REG_CLOSE_WAIT_TIMEOUT:
          cfg.close_wait_timeout  = val[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_CLOSE_TO_LOCK_DELAY:
          cfg.close_to_lock_delay = val[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_OPENING_TRAVEL_TIME:
          cfg.opening_travel_time = val[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_CLOSING_TRAVEL_TIME:
          cfg.closing_travel_time = val[dls_pkg::CFG_W-1:0];
        dls_pkg::REG_BUTTON_PRESS_TIME:
          cfg.button_press_time   = val[dls_pkg::PRESS_W-1:0];
        default: ;
      endcase
    endfunction

    function void mismatch(string what, int exp_val, int act_val);
      if (mismatches < 10)
        $display("MISMATCH %s: expected %0d, got %0d (word %0d)", what, exp_val, act_val,
                 words_checked);
      mismatches++;
    endfunction

    // saturating timer step
    function logic [TW-1:0] bump(logic [TW-1:0] t);
      return (&t) ? t : t + 1'b1;
    endfunction

    function void start_move(logic opening);
      travel_cnt = '0;
      press_left = cfg.button_press_time;
      press_open = opening;
      drive_st   = opening ? dls_pkg::DRV_OPENING : dls_pkg::DRV_CLOSING;
      seq_st     = dls_pkg::SEQ_CODE_MOVING;
      lock_st    = opening ? dls_pkg::LOCK_UNLOCKED : dls_pkg::LOCK_LOCKED;
      led_st     = opening ? dls_pkg::LED_GREEN : dls_pkg::LED_RED;
    endfunction

    function void apply_tick(logic [1:0] sense);
      door_st    = (sense == dls_pkg::DOOR_INVALID) ? dls_pkg::DOOR_UNKNOWN : sense;
      travel_cnt = bump(travel_cnt);
      wait_cnt   = bump(wait_cnt);
      delay_cnt  = bump(delay_cnt);
      if (press_left != 0) press_left = press_left - 1'b1;

      // end of lock travel
      if (drive_st == dls_pkg::DRV_OPENING && travel_cnt > cfg.opening_travel_time)
        drive_st = dls_pkg::DRV_STILL;
      else if (drive_st == dls_pkg::DRV_CLOSING && travel_cnt > cfg.closing_travel_time)
        drive_st = dls_pkg::DRV_STILL;

      if (seq_st == dls_pkg::SEQ_CODE_MOVING && drive_st == dls_pkg::DRV_STILL) begin
        seq_st = dls_pkg::SEQ_CODE_IDLE;
        led_st = dls_pkg::LED_OFF;
      end
      // waiting for the door, give up after the timeout
      if (seq_st == dls_pkg::SEQ_CODE_WAIT) begin
        if (wait_cnt > cfg.close_wait_timeout) begin
          seq_st = dls_pkg::SEQ_CODE_IDLE;
          led_st = dls_pkg::LED_OFF;
        end else if (door_st == dls_pkg::DOOR_CLOSED) begin
          seq_st    = dls_pkg::SEQ_CODE_DELAY;
          delay_cnt = '0;
        end
      end
      // door must stay closed for the delay before locking
      if (seq_st == dls_pkg::SEQ_CODE_DELAY) begin
        if (door_st != dls_pkg::DOOR_CLOSED)
          seq_st = dls_pkg::SEQ_CODE_WAIT;
        else if (delay_cnt > cfg.close_to_lock_delay)
          start_move(1'b0);
      end
    endfunction

    function void apply_action(logic [1:0] act);
      logic [1:0] eff;
      eff = act;
      if (act == dls_pkg::ACT_TOGGLE)
        eff = (lock_st <= dls_pkg::LOCK_LOCKED) ? dls_pkg::ACT_UNLOCK :
              dls_pkg::ACT_LOCK_CLOSED;
      if (seq_st == dls_pkg::SEQ_CODE_MOVING) return;
      case (eff)
        dls_pkg::ACT_CLOSE_NOW: start_move(1'b0);
        dls_pkg::ACT_LOCK_CLOSED: begin
          wait_cnt = '0;
          seq_st   = dls_pkg::SEQ_CODE_WAIT;
          led_st   = dls_pkg::LED_YELLOW_RED;
        end
        default: start_move(1'b1);
      endcase
    endfunction

    function void note_word(dls_pkg::in_word_t w);
      dls_pkg::out_word_t st;
      if (w.func == dls_pkg::FUNC_TICK) apply_tick(w.door_sense);
      else apply_action(w.action);
      st.lock_status     = lock_st;
      st.sequence_status = seq_st;
      st.led_mode        = led_st;
      st.open_button     = (press_left != 0) && press_open;
      st.close_button    = (press_left != 0) && !press_open;
      st.drive_moving    = (drive_st != dls_pkg::DRV_STILL);
      expected_status.push_back(st);
      words_in++;
    endfunction

    function void check_status(dls_pkg::out_word_t got);
      dls_pkg::out_word_t exp_st;
      if (expected_status.size() == 0) begin
        mismatch("status word with nothing expected", 0, int'(got));
        return;
      end
      exp_st = expected_status.pop_front();
      if (got.lock_status !== exp_st.lock_status)
        mismatch("lock_status", int'(exp_st.lock_status), int'(got.lock_status));
      if (got.sequence_status !== exp_st.sequence_status)
        mismatch("sequence_status", int'(exp_st.sequence_status),
                 int'(got.sequence_status));
      if (got.led_mode !== exp_st.led_mode)
        mismatch("led_mode", int'(exp_st.led_mode), int'(got.led_mode));
      if (got.open_button !== exp_st.open_button)
        mismatch("open_button", int'(exp_st.open_button), int'(got.open_button));
      if (got.close_button !== exp_st.close_button)
        mismatch("close_button", int'(exp_st.close_button), int'(got.close_button));
      if (got.drive_moving !== exp_st.drive_moving)
        mismatch("drive_moving", int'(exp_st.drive_moving), int'(got.drive_moving));
      words_checked++;
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  dls_pkg::in_word_t            in_word;
  logic                         out_valid;
  logic                         out_stall;
  dls_pkg::out_word_t           out_word;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dls_pkg::PADDR_W-1:0]  paddr;
  logic [dls_pkg::PDATA_W-1:0]  pwdata;
  logic [dls_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  lock_scoreboard sb = new();

  bit         idle_on = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         cycle_count = 0;
  int         settings_run = 0;
  int         holds_done = 0;
  logic [1:0] door_now = dls_pkg::DOOR_CLOSED;

  door_lock_sequencer dut (.*);

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_status(out_word);
  end

  // run limit
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stall runs plus an occasional long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (idle_on) stall_left = gap_len();
      end
    end
  end

  function automatic dls_pkg::in_word_t mk_tick(logic [1:0] sense);
    dls_pkg::in_word_t w;
    w.func = dls_pkg::FUNC_TICK;
    w.action = 2'($urandom_range(0, 3));
    w.door_sense = sense;
    return w;
  endfunction

  function automatic dls_pkg::in_word_t mk_action(logic [1:0] act);
    dls_pkg::in_word_t w;
    w.func = dls_pkg::FUNC_ACTION;
    w.action = act;
    w.door_sense = 2'($urandom_range(0, 3));
    return w;
  endfunction

  // mostly ticks with a sticky door sensor, some actions
  function automatic dls_pkg::in_word_t random_word();
    int r;
    if ($urandom_range(0, 15) == 0) begin
      r = $urandom_range(0, 3);
      door_now = (r < 2) ? dls_pkg::DOOR_CLOSED :
                 (r == 2) ? dls_pkg::DOOR_OPEN : dls_pkg::DOOR_UNKNOWN;
    end
    if ($urandom_range(0, 99) < 78)
      return mk_tick(($urandom_range(0, 40) == 0) ? dls_pkg::DOOR_INVALID : door_now);
    return mk_action(2'($urandom_range(0, 3)));
  endfunction

  function automatic dls_pkg::cfg_t make_cfg(int wt, int dl, int op, int cl, int pr);
    dls_pkg::cfg_t c;
    c.close_wait_timeout  = dls_pkg::CFG_W'(wt);
    c.close_to_lock_delay = dls_pkg::CFG_W'(dl);
    c.opening_travel_time = dls_pkg::CFG_W'(op);
    c.closing_travel_time = dls_pkg::CFG_W'(cl);
    c.button_press_time   = dls_pkg::PRESS_W'(pr);
    return c;
  endfunction

  // offer one word, hold it until taken; valid stays high for back-to-back words
  task automatic send_word(dls_pkg::in_word_t w);
    int gap;
    gap = idle_on ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_word  = 5'($urandom_range(0, 31));
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  // drop valid and let every expected status word come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // apb write followed by a read back
  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd !== val)
      sb.mismatch($sformatf("read back of register %0d", idx), int'(val), int'(rd));
  endtask

  task automatic load_cfg(dls_pkg::cfg_t c);
    write_register(dls_pkg::REG_CLOSE_WAIT_TIMEOUT,  32'(c.close_wait_timeout));
    write_register(dls_pkg::REG_CLOSE_TO_LOCK_DELAY, 32'(c.close_to_lock_delay));
    write_register(dls_pkg::REG_OPENING_TRAVEL_TIME, 32'(c.opening_travel_time));
    write_register(dls_pkg::REG_CLOSING_TRAVEL_TIME, 32'(c.closing_travel_time));
    write_register(dls_pkg::REG_BUTTON_PRESS_TIME,   32'(c.button_press_time));
    settings_run++;
  endtask

  task automatic run_phase(dls_pkg::cfg_t c, int n, bit quiet, bit squeeze);
    wait_idle();
    load_cfg(c);
    idle_on = !quiet;
    if (squeeze) hold_req = 1'b1;
    repeat (n) send_word(random_word());
  endtask

  // main sequence
  initial begin
    int total_fail;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_word  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: every sensor code, toggle from unknown, actions ignored while moving
    send_word(mk_tick(dls_pkg::DOOR_UNKNOWN));
    send_word(mk_tick(dls_pkg::DOOR_CLOSED));
    send_word(mk_tick(dls_pkg::DOOR_OPEN));
    send_word(mk_tick(dls_pkg::DOOR_INVALID));
    send_word(mk_action(dls_pkg::ACT_TOGGLE));
    send_word(mk_action(dls_pkg::ACT_CLOSE_NOW));
    send_word(mk_action(dls_pkg::ACT_LOCK_CLOSED));

    // short timings: a toggle while the open move still runs is ignored, then ticks finish the move with a door bounce
    wait_idle();
    load_cfg(make_cfg(20, 5, 8, 6, 3));
    repeat (7) send_word(mk_tick(dls_pkg::DOOR_OPEN));
    send_word(mk_action(dls_pkg::ACT_TOGGLE));
    send_word(mk_tick(dls_pkg::DOOR_OPEN));
    send_word(mk_tick(dls_pkg::DOOR_CLOSED));
    send_word(mk_tick(dls_pkg::DOOR_OPEN));
    repeat (7) send_word(mk_tick(dls_pkg::DOOR_CLOSED));

    // random phases across settings, extremes included
    run_phase(make_cfg(20, 5, 8, 6, 3), 250, 1'b0, 1'b1);
    run_phase(make_cfg(0, 0, 0, 0, 1), 200, 1'b0, 1'b0);
    run_phase(make_cfg(65535, 65535, 65535, 65535, 1023), 150, 1'b0, 1'b0);
    run_phase(make_cfg($urandom_range(0, 60), $urandom_range(0, 30), $urandom_range(0, 40),
                       $urandom_range(0, 40), $urandom_range(1, 50)), 250, 1'b1, 1'b0);
    repeat (3)
      run_phase(make_cfg($urandom_range(0, 60), $urandom_range(0, 30), $urandom_range(0, 40),
                         $urandom_range(0, 40), $urandom_range(1, 50)), 250, 1'b0, 1'b0);
    run_phase(make_cfg($urandom_range(100, 800), $urandom_range(0, 100),
                       $urandom_range(100, 600), $urandom_range(100, 600),
                       $urandom_range(200, 1023)), 250, 1'b0, 1'b1);

    wait_idle();
    repeat (5) @(posedge clk);
    total_fail = sb.mismatches + sb.expected_status.size();
    $display("Covered %0d input words over %0d register settings with %0d long output holds",
             sb.words_in, settings_run, holds_done);
    $display("Checked %0d status words, %0d mismatches", sb.words_checked, sb.mismatches);
    if (total_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dls_pkg.sv
sv/dls_core.sv
sv/door_lock_sequencer.sv
dv/tb.sv
